// ===== sv/dct_pkg.sv =====
// ---------------------------------------------------------------------------
// dct_pkg: shared types and constants for the dirty chunk tracker
// Sizes of the byte store and of the two-level dirty bitmap, action codes,
// the controller-to-datapath command group and the priority encoders.
// ---------------------------------------------------------------------------
`default_nettype none

package dct_pkg;

  // Store and bitmap geometry (all powers of two)
  localparam int unsigned StoreBytes   = 65536;
  localparam int unsigned ChunkBytes   = 32;
  localparam int unsigned MaskWordBits = 64;
  localparam int unsigned NumChunks    = StoreBytes / ChunkBytes;
  localparam int unsigned NumWords     = NumChunks / MaskWordBits;

  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned ChunkShift = $clog2(ChunkBytes);
  localparam int unsigned BitW       = $clog2(MaskWordBits);
  localparam int unsigned WordW      = $clog2(NumWords);
  localparam int unsigned ActionW    = 3;
  localparam int unsigned DataW      = 8;
  localparam int unsigned OffsetW    = 16;

  // Action codes carried on the input transfer
  typedef enum logic [ActionW-1:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_LOAD  = 3'd2,
    ACT_POP   = 3'd3,
    ACT_CLEAR = 3'd4
  } action_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // input transfer: latch item, issue memory reads
    logic execute;  // commit updates and load the result register
  } dct_cmd_t;

  // Index of the lowest set bit of a summary word, zero when empty
  function automatic logic [WordW-1:0] lowest_word(input logic [NumWords-1:0] v);
    logic [WordW-1:0] idx;
    idx = '0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WordW'(i);
      end
    end
    return idx;
  endfunction

  // Index of the lowest set bit of a mask word, zero when empty
  function automatic logic [BitW-1:0] lowest_bit(input logic [MaskWordBits-1:0] v);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = MaskWordBits - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BitW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dirty_chunk_tracker.sv =====
// An input transfer captures the item and execute registers its result; one item
// is in flight at a time, in a read-then-write pass over
// the single-port byte store and mask word memory.
// A stalled result holds the next item in its execute cycle until taken.
// Reset clears all dirty marks at once (valid bit per mask word); stored
// bytes are undefined until written or loaded.
// ---------------------------------------------------------------------------
// dirty_chunk_tracker: byte store with per-chunk change tracking
// Tracked writes mark 32-byte chunks in a two-level bitmap; pop returns and
// clears the lowest dirty chunk; clear-all drops every mark.
// ---------------------------------------------------------------------------
`default_nettype none

module dirty_chunk_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [dct_pkg::ActionW-1:0]    in_action_i,
  input  wire logic [dct_pkg::AddrW-1:0]      in_address_i,
  input  wire logic [dct_pkg::DataW-1:0]      in_write_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [dct_pkg::DataW-1:0]      out_read_data_o,
  output logic      [dct_pkg::OffsetW-1:0]    out_region_offset_o,
  output logic                                out_found_o,
  output logic                                out_changed_o
);

  dct_pkg::dct_cmd_t cmd;

  dct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dct_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .in_action_i         (in_action_i),
    .in_address_i        (in_address_i),
    .in_write_data_i     (in_write_data_i),
    .out_read_data_o     (out_read_data_o),
    .out_region_offset_o (out_region_offset_o),
    .out_found_o         (out_found_o),
    .out_changed_o       (out_changed_o)
  );

`ifndef ASSERT_OFF
  // One item at a time: an input transfer closes the input side next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // A pop never reports a changed byte
  a_found_not_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_found_o && out_changed_o))
    else $error("found and changed both set");

  // An offset is only reported with a found chunk
  a_offset_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_found_o) |-> (out_region_offset_o == '0))
    else $error("region offset without found chunk");
`endif

endmodule

`default_nettype wire

// ===== sv/dct_ctrl.sv =====
// ---------------------------------------------------------------------------
// dct_ctrl: sequencing controller
// Two-state machine: take an item, then commit it once the result
// register is free. Owns the input stall and the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module dct_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dct_pkg::dct_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // Result slot can take a new item when empty or being drained
  assign slot_free = !out_valid_q || !out_stall_i;

  assign in_stall_o    = (state_q != S_IDLE);
  assign cmd_o.capture = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.execute = (state_q == S_EXEC) && slot_free;
  assign out_valid_o   = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on commit, cleared on output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dct_datapath.sv =====
// ---------------------------------------------------------------------------
// dct_datapath: byte store, dirty bitmap and result registers
// Reads the byte and the relevant mask word on capture, then performs the
// read-modify-write of store and bitmap on execute.
// ---------------------------------------------------------------------------
`default_nettype none

module dct_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dct_pkg::dct_cmd_t                cmd_i,
  input  wire logic [dct_pkg::ActionW-1:0]      in_action_i,
  input  wire logic [dct_pkg::AddrW-1:0]        in_address_i,
  input  wire logic [dct_pkg::DataW-1:0]        in_write_data_i,
  output logic      [dct_pkg::DataW-1:0]        out_read_data_o,
  output logic      [dct_pkg::OffsetW-1:0]      out_region_offset_o,
  output logic                                  out_found_o,
  output logic                                  out_changed_o
);

  localparam int unsigned WordW = dct_pkg::WordW;
  localparam int unsigned BitW  = dct_pkg::BitW;
  localparam int unsigned MaskW = dct_pkg::MaskWordBits;
  localparam int unsigned NumW  = dct_pkg::NumWords;

  // Memories
  logic [dct_pkg::DataW-1:0] store_mem [dct_pkg::StoreBytes];
  logic [MaskW-1:0]          dirty_mem [NumW];

  // Marks state (reset)
  logic [NumW-1:0] dvalid_q, dvalid_d;
  logic [NumW-1:0] summary_q, summary_d;

  // Captured item and read data
  dct_pkg::action_e          act_q;
  logic [dct_pkg::AddrW-1:0] addr_q;
  logic [dct_pkg::DataW-1:0] data_q;
  logic [dct_pkg::DataW-1:0] byte_rd_q;
  logic [MaskW-1:0]          dirty_rd_q;
  logic                      dvalid_rd_q;
  logic [WordW-1:0]          widx_q;
  logic                      any_q;

  // Execute-stage logic
  logic [WordW-1:0]          widx_c;
  logic [MaskW-1:0]          word_cur;
  logic [MaskW-1:0]          word_new;
  logic [BitW-1:0]           mark_bit;
  logic [BitW-1:0]           pop_bit;
  logic                      changed_c;
  logic                      pop_go;
  logic                      store_we;
  logic                      dirty_we;

  // Word to look at: lowest dirty word for a pop, else the address's word
  always_comb begin
    if (dct_pkg::action_e'(in_action_i) == dct_pkg::ACT_POP) begin
      widx_c = dct_pkg::lowest_word(summary_q);
    end else begin
      widx_c = in_address_i[dct_pkg::ChunkShift + BitW +: WordW];
    end
  end

  // Capture registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q       <= dct_pkg::action_e'(in_action_i);
      addr_q      <= in_address_i;
      data_q      <= in_write_data_i;
      widx_q      <= widx_c;
      dvalid_rd_q <= dvalid_q[widx_c];
      any_q       <= |summary_q;
    end
  end

  // Execute: compare, mark, pop
  assign word_cur  = dvalid_rd_q ? dirty_rd_q : '0;
  assign mark_bit  = addr_q[dct_pkg::ChunkShift +: BitW];
  assign pop_bit   = dct_pkg::lowest_bit(word_cur);
  assign changed_c = (act_q == dct_pkg::ACT_WRITE) && (byte_rd_q != data_q);
  assign pop_go    = (act_q == dct_pkg::ACT_POP) && any_q;
  assign store_we  = cmd_i.execute && (changed_c || (act_q == dct_pkg::ACT_LOAD));
  assign dirty_we  = cmd_i.execute && (changed_c || pop_go);

  always_comb begin
    if (changed_c) begin
      word_new = word_cur | (MaskW'(1) << mark_bit);
    end else begin
      word_new = word_cur & ~(MaskW'(1) << pop_bit);
    end
  end

  // Byte store: registered read on capture, write on execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_rd_q <= store_mem[in_address_i];
    end
    if (store_we) begin
      store_mem[addr_q] <= data_q;
    end
  end

  // Mask word memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dirty_rd_q <= dirty_mem[widx_c];
    end
    if (dirty_we) begin
      dirty_mem[widx_q] <= word_new;
    end
  end

  // Word valid bits and summary bitmap
  always_comb begin
    dvalid_d  = dvalid_q;
    summary_d = summary_q;
    if (cmd_i.execute && (act_q == dct_pkg::ACT_CLEAR)) begin
      dvalid_d  = '0;
      summary_d = '0;
    end else if (dirty_we) begin
      dvalid_d[widx_q] = 1'b1;
      if (changed_c) begin
        summary_d[widx_q] = 1'b1;
      end else if (word_new == '0) begin
        summary_d[widx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q  <= '0;
      summary_q <= '0;
    end else begin
      dvalid_q  <= dvalid_d;
      summary_q <= summary_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_read_data_o <= (act_q == dct_pkg::ACT_READ) ? byte_rd_q : '0;
      out_found_o     <= pop_go;
      out_changed_o   <= changed_c;
      if (pop_go) begin
        out_region_offset_o <= dct_pkg::OffsetW'({widx_q, pop_bit}) << dct_pkg::ChunkShift;
      end else begin
        out_region_offset_o <= '0;
      end
    end
  end

endmodule

`default_nettype wire
